/* hdl/bfbp_pkg.sv */
// Package for the best-fit buffer pool: sizes, field widths, codes and the
// structs passed between the controller and the row of table cells.
// No dependencies.
package bfbp_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int SIZE_W        = 40;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int SLOT_W        = IDX_W;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int STATUS_W      = 3;

    localparam int IN_BITS    = SIZE_W + SLOT_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = SLOT_W + SIZE_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic {
        ACT_ACQUIRE = 1'b0,
        ACT_RELEASE = 1'b1
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_REUSED      = 3'd0,
        ST_NEW         = 3'd1,
        ST_FULL        = 3'd2,
        ST_RELEASED    = 3'd3,
        ST_BAD_RELEASE = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              active;
        logic [SIZE_W-1:0] req;
        logic              found;
        logic [IDX_W-1:0]  best_idx;
        logic [SIZE_W-1:0] best_size;
    } t_scan;

    typedef struct packed {
        logic append;
        logic set_free;
        logic clr_free;
    } t_cell_ctl;

endpackage

/* hdl/bfbp_cell.sv */
// One table entry of the buffer pool with its stage of the best-fit search.
// Depends on bfbp_pkg.
module bfbp_cell import bfbp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [IDX_W-1:0]  i_idx,
    input  t_scan             i_scan,
    output t_scan             o_scan,
    input  t_cell_ctl         i_ctl,
    input  logic [SIZE_W-1:0] i_wr_size,
    output logic              o_used,
    output logic              o_free
);

    logic              r_used;
    logic              r_free;
    logic [SIZE_W-1:0] r_size;
    t_scan             r_scan;
    t_scan             n_scan;
    logic              w_hit;
    logic              w_better;

    assign w_hit    = r_used && r_free && (i_scan.req <= r_size);
    assign w_better = w_hit && (!i_scan.found || (r_size < i_scan.best_size));

    always_comb begin
        n_scan = i_scan;
        if (w_better) begin
            n_scan.found     = 1'b1;
            n_scan.best_idx  = i_idx;
            n_scan.best_size = r_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan.active <= 1'b0;
        end else begin
            r_scan <= n_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_free <= 1'b0;
        end else begin
            if (i_ctl.append) begin
                r_used <= 1'b1;
                r_free <= 1'b0;
            end else if (i_ctl.set_free) begin
                r_free <= 1'b1;
            end else if (i_ctl.clr_free) begin
                r_free <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.append) begin
            r_size <= i_wr_size;
        end
    end

    assign o_scan = r_scan;
    assign o_used = r_used;
    assign o_free = r_free;

endmodule

/* hdl/best_fit_buffer_pool.sv */
// Top level of the best-fit buffer pool: stream ports, controller and the
// row of table cells. Depends on bfbp_pkg and bfbp_cell.
//
// Use: each transfer on the s_axis side is one request. s_axis_tuser is the
// action (0 acquire, 1 release); s_axis_tdata carries the requested size and
// the slot to release. Each request gives exactly one transfer on the m_axis
// side: granted slot and size in m_axis_tdata, status code in m_axis_tuser.
// An acquire sends a search token down the row of TABLE_ENTRIES cells, one
// cell per cycle, each cell keeping the smallest fitting free entry so far.
// The search result is registered as the token leaves the row and is then
// moved into the output register once that register is free; only after
// that is the next request taken. A release needs no search and goes
// straight to the output register.
// One request is in work at a time. A finished result waits in the output
// register while the next request is taken and searched; when the receiver
// stalls, the following result holds until the register is taken.
// Synchronous reset empties the table: no entries, nothing free, no result.
module best_fit_buffer_pool import bfbp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // req_size, slot_index, zero pad
    input  logic                   s_axis_tuser,  // action
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // granted_slot, granted_size, zero pad
    output logic [STATUS_W-1:0]    m_axis_tuser   // status
);

    t_state            r_state;
    t_state            n_state;
    logic              r_act;
    logic [SIZE_W-1:0] r_req;
    logic [SLOT_W-1:0] r_slot;
    logic              r_found;
    logic [IDX_W-1:0]  r_best_idx;
    logic [SIZE_W-1:0] r_best_size;
    logic [CNT_W-1:0]  r_count;
    logic              r_out_valid;
    logic [SLOT_W-1:0] r_out_slot;
    logic [SIZE_W-1:0] r_out_size;
    t_status           r_out_status;

    logic              w_accept;
    logic              w_commit;
    logic              w_do_append;
    logic              w_release_ok;
    logic              w_has_room;
    t_status           w_status;
    logic [SLOT_W-1:0] w_res_slot;
    logic [SIZE_W-1:0] w_res_size;
    logic [SIZE_W-1:0] w_in_req;
    logic [SLOT_W-1:0] w_in_slot;

    t_scan             w_scan [TABLE_ENTRIES+1];
    t_cell_ctl         w_ctl  [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] w_used;
    logic [TABLE_ENTRIES-1:0] w_free;
    logic [TABLE_ENTRIES-1:0] w_any_ctl;

    assign w_in_req  = s_axis_tdata[SIZE_W-1:0];
    assign w_in_slot = s_axis_tdata[SIZE_W+SLOT_W-1:SIZE_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_commit      = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    assign w_scan[0].active    = w_accept && (t_action'(s_axis_tuser) == ACT_ACQUIRE);
    assign w_scan[0].req       = w_in_req;
    assign w_scan[0].found     = 1'b0;
    assign w_scan[0].best_idx  = '0;
    assign w_scan[0].best_size = '0;

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            always_comb begin
                w_ctl[g].append   = w_do_append && (r_count == CNT_W'(g));
                w_ctl[g].set_free = w_commit && (t_action'(r_act) == ACT_RELEASE)
                                    && w_release_ok && (CNT_W'(r_slot) == CNT_W'(g));
                w_ctl[g].clr_free = w_commit && (t_action'(r_act) == ACT_ACQUIRE)
                                    && r_found && (r_best_idx == IDX_W'(g));
            end
            assign w_any_ctl[g] = w_ctl[g].append | w_ctl[g].set_free | w_ctl[g].clr_free;

            bfbp_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_idx     (IDX_W'(g)),
                .i_scan    (w_scan[g]),
                .o_scan    (w_scan[g+1]),
                .i_ctl     (w_ctl[g]),
                .i_wr_size (r_req),
                .o_used    (w_used[g]),
                .o_free    (w_free[g])
            );
        end
    endgenerate

    assign w_has_room   = (r_count != CNT_W'(TABLE_ENTRIES));
    assign w_release_ok = (CNT_W'(r_slot) < r_count) && w_used[r_slot] && !w_free[r_slot];
    assign w_do_append  = w_commit && (t_action'(r_act) == ACT_ACQUIRE) && !r_found
                          && w_has_room;

    always_comb begin
        w_status   = ST_FULL;
        w_res_slot = '0;
        w_res_size = '0;
        if (t_action'(r_act) == ACT_RELEASE) begin
            w_res_slot = r_slot;
            w_status   = w_release_ok ? ST_RELEASED : ST_BAD_RELEASE;
        end else if (r_found) begin
            w_res_slot = r_best_idx;
            w_res_size = r_best_size;
            w_status   = ST_REUSED;
        end else if (w_has_room) begin
            w_res_slot = SLOT_W'(r_count);
            w_res_size = r_req;
            w_status   = ST_NEW;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (t_action'(s_axis_tuser) == ACT_ACQUIRE) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (w_scan[TABLE_ENTRIES].active) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act  <= s_axis_tuser;
            r_req  <= w_in_req;
            r_slot <= w_in_slot;
        end
        if ((r_state == S_SCAN) && w_scan[TABLE_ENTRIES].active) begin
            r_found     <= w_scan[TABLE_ENTRIES].found;
            r_best_idx  <= w_scan[TABLE_ENTRIES].best_idx;
            r_best_size <= w_scan[TABLE_ENTRIES].best_size;
        end
        if (w_commit) begin
            r_out_slot   <= w_res_slot;
            r_out_size   <= w_res_size;
            r_out_status <= w_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_do_append) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out_size, r_out_slot});
    assign m_axis_tuser  = r_out_status;

    a_scan_only_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan[TABLE_ENTRIES].active |-> (r_state == S_SCAN))
        else $error("search token left the row outside a search");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_append |=> (r_count == $past(r_count) + CNT_W'(1)) && (r_out_status == ST_NEW))
        else $error("append did not grow the table");

    a_one_cell_updated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_any_ctl) && ((w_any_ctl == '0) || w_commit))
        else $error("table update outside commit or on several cells");

    a_reuse_marks_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && (w_status == ST_REUSED)) |=> !w_free[$past(r_best_idx)])
        else $error("reused entry still marked free");

endmodule
